// File: hdl/rbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants for the ray/box slab test
// Q16.16 limits, divider depth and configuration register indexes.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int DIV_STAGES = 32;              // one quotient bit per stage
    localparam int DIV_LAT    = DIV_STAGES + 1;  // plus the saturation register

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

endpackage

// File: hdl/rbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_div: pipelined saturating Q16.16 divider
// Restoring division of a 49-bit magnitude by a 32-bit magnitude, one
// quotient bit per stage, then sign and saturation to signed 32 bits.
// ----------------------------------------------------------------------------
module rbs_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [48:0]        i_num,
    input  logic [31:0]        i_den,
    input  logic               i_neg,
    output logic signed [31:0] o_quo
);

    localparam int NS = rbs_pkg::DIV_STAGES;

    logic [31:0] r_rem [NS];
    logic [31:0] r_lo  [NS];
    logic [31:0] r_q   [NS];
    logic [31:0] r_den [NS];
    logic        r_neg [NS];
    logic        r_ovf [NS];
    logic signed [31:0] r_quo;
    logic signed [31:0] n_quo;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [31:0] p_rem, p_lo, p_q, p_den;
            logic        p_neg, p_ovf;
            logic [32:0] trial;
            logic        ge;

            if (k == 0) begin : g_first
                // high part already >= divisor means quotient needs 33+ bits
                assign p_rem = {15'd0, i_num[48:32]};
                assign p_lo  = i_num[31:0];
                assign p_q   = '0;
                assign p_den = i_den;
                assign p_neg = i_neg;
                assign p_ovf = ({15'd0, i_num[48:32]} >= i_den);
            end else begin : g_next
                assign p_rem = r_rem[k-1];
                assign p_lo  = r_lo[k-1];
                assign p_q   = r_q[k-1];
                assign p_den = r_den[k-1];
                assign p_neg = r_neg[k-1];
                assign p_ovf = r_ovf[k-1];
            end

            assign trial = {p_rem, p_lo[31]};
            assign ge    = (trial >= {1'b0, p_den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? 32'(trial - {1'b0, p_den}) : trial[31:0];
                    r_lo[k]  <= {p_lo[30:0], 1'b0};
                    r_q[k]   <= {p_q[30:0], ge};
                    r_den[k] <= p_den;
                    r_neg[k] <= p_neg;
                    r_ovf[k] <= p_ovf;
                end
            end
        end
    endgenerate

    always_comb begin
        logic [31:0] q;
        q = r_q[NS-1];
        if (r_ovf[NS-1]) begin
            n_quo = r_neg[NS-1] ? rbs_pkg::Q_MIN : rbs_pkg::Q_MAX;
        end else if (r_neg[NS-1]) begin
            n_quo = (q > 32'h8000_0000) ? rbs_pkg::Q_MIN : $signed(32'(-q));
        end else begin
            n_quo = q[31] ? rbs_pkg::Q_MAX : $signed(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

// File: hdl/ray_box_slab_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_top: ray against axis-aligned box, slab method
// Six pipelined dividers give the slab crossings; entry/exit reduce to hit.
// ----------------------------------------------------------------------------
// Usage:
//   Box bounds are written on the cfg channel (index 0..5: min x,y,z then
//   max x,y,z, signed Q16.16); cfg_ready is always high, writes to other
//   indexes are dropped. Write them only while no ray is in flight.
//   Each input beat carries ray origin and direction (signed Q16.16) and
//   yields exactly one output beat with hit.
//   Throughput: one ray per cycle unless the output stalls. Stages to
//   output valid: one prep stage, 32 divider bit stages plus a
//   saturation stage, one per-axis min/max stage and the output register.
//   Reset clears the box bounds and all valid bits.
//   The whole pipeline advances together; when the output holds an
//   unaccepted beat and ready is low, the pipe freezes and in_ready drops,
//   so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_test_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit
);

    localparam int LAT = rbs_pkg::DIV_LAT;
    localparam int VL  = LAT + 3;

    logic signed [31:0] r_bmin [3];
    logic signed [31:0] r_bmax [3];
    logic [VL-1:0]      r_vld;
    logic               en;

    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];

    // prep stage: index 2a is the lower bound, 2a+1 the upper
    logic [48:0] r_num [6];
    logic [31:0] r_den [6];
    logic        r_neg [6];
    logic [2:0]  r_zero;
    logic [2:0]  r_zd [LAT];
    logic signed [31:0] quo [6];

    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];
    logic               r_hit;

    assign en          = !r_vld[VL-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[VL-1];
    assign o_hit       = r_hit;

    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_bmin[a] <= '0;
                r_bmax[a] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (rbs_pkg::t_cfg_idx'(i_cfg_index))
                rbs_pkg::CFG_MIN_X: r_bmin[0] <= i_cfg_data;
                rbs_pkg::CFG_MIN_Y: r_bmin[1] <= i_cfg_data;
                rbs_pkg::CFG_MIN_Z: r_bmin[2] <= i_cfg_data;
                rbs_pkg::CFG_MAX_X: r_bmax[0] <= i_cfg_data;
                rbs_pkg::CFG_MAX_Y: r_bmax[1] <= i_cfg_data;
                rbs_pkg::CFG_MAX_Z: r_bmax[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VL-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic signed [31:0] bnd;
        if (en) begin
            for (int j = 0; j < 6; j++) begin
                bnd  = j[0] ? r_bmax[j/2] : r_bmin[j/2];
                diff = 33'(bnd) - 33'(org[j/2]);
                mag  = diff[32] ? 33'(-diff) : diff;
                r_num[j] <= {mag, 16'd0};
                r_den[j] <= dir[j/2][31] ? 32'(-dir[j/2]) : dir[j/2];
                r_neg[j] <= diff[32] ^ dir[j/2][31];
            end
            for (int a = 0; a < 3; a++) begin
                r_zero[a] <= (dir[a] == 32'sd0);
            end
            r_zd[0] <= r_zero;
            for (int k = 1; k < LAT; k++) begin
                r_zd[k] <= r_zd[k-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < 6; g++) begin : g_div
            rbs_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r_num[g]),
                .i_den (r_den[g]),
                .i_neg (r_neg[g]),
                .o_quo (quo[g])
            );
        end
    endgenerate

    // r_zd[LAT-1] lines up with the divider outputs
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                if (r_zd[LAT-1][a]) begin
                    r_lo[a] <= rbs_pkg::Q_MIN;
                    r_hi[a] <= rbs_pkg::Q_MAX;
                end else if (quo[2*a] < quo[2*a+1]) begin
                    r_lo[a] <= quo[2*a];
                    r_hi[a] <= quo[2*a+1];
                end else begin
                    r_lo[a] <= quo[2*a+1];
                    r_hi[a] <= quo[2*a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] enter;
        logic signed [31:0] leave;
        if (en) begin
            enter = rbs_pkg::Q_MIN;
            leave = rbs_pkg::Q_MAX;
            for (int a = 0; a < 3; a++) begin
                if (r_lo[a] > enter) enter = r_lo[a];
                if (r_hi[a] < leave) leave = r_hi[a];
            end
            r_hit <= (enter > 32'sd0) && (enter < leave);
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the ray/box slab test
// Walks a short table of directed rays, then random rays under several box
// settings. Random stalls sit on both channels. Every output beat is checked
// against a Q16.16 slab predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM  = 1400;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [31:0] i_dir_x, i_dir_y, i_dir_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_hit;

    ray_box_slab_test_top i_dut (.*);

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [31:0] dir [3];
    } t_ray;

    logic signed [31:0] box_lo [3];
    logic signed [31:0] box_hi [3];
    logic               hit_queue [$];
    int                 errors;
    int                 idle_cycles;
    bit                 long_hold;   // receiver holds off for a long stretch
    bit                 stim_done;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] slab_cross(logic signed [31:0] bound,
            logic signed [31:0] org, logic signed [31:0] dir);
        logic signed [63:0] num;
        logic signed [63:0] q;
        num = (64'(bound) - 64'(org)) * 64'sd65536;
        q   = num / 64'(dir);
        if (q > 64'(rbs_pkg::Q_MAX)) return rbs_pkg::Q_MAX;
        if (q < 64'(rbs_pkg::Q_MIN)) return rbs_pkg::Q_MIN;
        return q[31:0];
    endfunction

    function automatic logic ray_hits(t_ray r);
        logic signed [31:0] enter, leave, t1, t2, lo, hi;
        enter = rbs_pkg::Q_MIN;
        leave = rbs_pkg::Q_MAX;
        for (int a = 0; a < 3; a++) begin
            if (r.dir[a] == 0) begin
                lo = rbs_pkg::Q_MIN;
                hi = rbs_pkg::Q_MAX;
            end else begin
                t1 = slab_cross(box_lo[a], r.org[a], r.dir[a]);
                t2 = slab_cross(box_hi[a], r.org[a], r.dir[a]);
                lo = (t1 < t2) ? t1 : t2;
                hi = (t1 < t2) ? t2 : t1;
            end
            if (lo > enter) enter = lo;
            if (hi < leave) leave = hi;
        end
        return (enter > 0 && enter < leave);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len(int max_long);
        if ($urandom_range(0, 2) == 0) return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(5, max_long)
                                            : $urandom_range(0, 3);
    endfunction

    // sender idles between beats; valid drops only when a gap follows
    task automatic in_gap(int max_long);
        int n;
        n = gap_len(max_long);
        if (n == 0) return;
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < 3'd3) box_lo[2'(idx)] = data;
        else if (idx < 3'd6) box_hi[2'(idx - 3'd3)] = data;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic set_box(logic [31:0] v [6]);
        wait_idle();
        cfg_write(rbs_pkg::CFG_MIN_X, v[0]);
        cfg_write(rbs_pkg::CFG_MIN_Y, v[1]);
        cfg_write(rbs_pkg::CFG_MIN_Z, v[2]);
        cfg_write(rbs_pkg::CFG_MAX_X, v[3]);
        cfg_write(rbs_pkg::CFG_MAX_Y, v[4]);
        cfg_write(rbs_pkg::CFG_MAX_Z, v[5]);
        // indexes past the last register are dropped
        cfg_write(3'd6, $urandom());
        cfg_write(3'd7, $urandom());
        i_cfg_valid <= 1'b0;
    endtask

    // exp: -1 skips the table check, else the typed-in value must match the predictor
    task automatic send_ray(t_ray r, int exp);
        logic h;
        h = ray_hits(r);
        if (exp >= 0 && h !== exp[0]) begin
            $display("%0t: table row disagrees with predictor: expected %0d, actual %0d",
                     $time, exp, h);
            errors++;
        end
        i_in_valid <= 1'b1;
        i_origin_x <= r.org[0]; i_origin_y <= r.org[1]; i_origin_z <= r.org[2];
        i_dir_x    <= r.dir[0]; i_dir_y    <= r.dir[1]; i_dir_z    <= r.dir[2];
        do @(posedge i_clk); while (!o_in_ready);
        hit_queue.push_back(h);
    endtask

    function automatic logic signed [31:0] rand_q(int spread);
        case ($urandom_range(0, 9))
            0: return rbs_pkg::Q_MIN;
            1: return rbs_pkg::Q_MAX;
            2: return 0;
            3: return $urandom();
            default: return $signed($urandom_range(0, 2 * spread)) - spread;
        endcase
    endfunction

    // well-formed ray: aimed from a nearby origin toward a point near the box
    function automatic t_ray aimed_ray();
        t_ray r;
        logic signed [63:0] tgt, o;
        for (int a = 0; a < 3; a++) begin
            tgt = (64'(box_lo[a]) + 64'(box_hi[a])) / 2
                  + $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            o   = tgt + $signed($urandom_range(0, 64 << 16)) - (32 << 16);
            if (o > 64'(rbs_pkg::Q_MAX)) o = 64'(rbs_pkg::Q_MAX);
            if (o < 64'(rbs_pkg::Q_MIN)) o = 64'(rbs_pkg::Q_MIN);
            r.org[a] = o[31:0];
            r.dir[a] = 32'((tgt - o) / 4);
            if ($urandom_range(0, 15) == 0) r.dir[a] = 0;
        end
        return r;
    endfunction

    function automatic t_ray mk(int ox, int oy, int oz, int dx, int dy, int dz);
        t_ray r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        return r;
    endfunction

    localparam int ONE = 32'h0001_0000;

    initial begin
        logic [31:0] bx [6];
        t_ray        dir_tbl [$];
        int          dir_exp [$];
        t_ray        r;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_origin_x = '0; i_origin_y = '0; i_origin_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        errors = 0; stim_done = 0; long_hold = 0;
        for (int a = 0; a < 3; a++) begin box_lo[a] = 0; box_hi[a] = 0; end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: empty box, nothing is hit
        send_ray(mk(0, 0, 0, 0, 0, 0), 0);
        send_ray(mk(-ONE, 0, 0, ONE, 0, 0), 0);

        bx = '{-ONE, -ONE, -ONE, ONE, ONE, ONE};
        set_box(bx);
        dir_tbl = '{
            mk(-4*ONE, 0, 0, ONE, 0, 0),          // straight in on x
            mk(4*ONE, 0, 0, ONE, 0, 0),           // box behind the origin
            mk(0, 0, 0, ONE, ONE, ONE),           // origin inside: entry < 0
            mk(-4*ONE, 4*ONE, 0, ONE, 0, 0),      // zero dir on y: no limit there
            mk(-4*ONE, -4*ONE, -4*ONE, ONE, ONE, ONE),
            mk(-4*ONE, 0, 0, 1, 0, 0),            // tiny dir: both ends saturate
            mk(-4*ONE, 0, 0, 32'h8000_0000, 0, 0),
            mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0),
            mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0),
            mk(-ONE, 0, 0, ONE, 0, 0),            // entry exactly zero
            mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1, -1, -1),
            mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)
        };
        dir_exp = '{1, 0, 0, 1, 1, 0, -1, -1, -1, 0, -1, -1};
        foreach (dir_tbl[k]) begin
            send_ray(dir_tbl[k], dir_exp[k]);
            in_gap(6);
        end

        // inverted box and full-range bounds
        bx = '{ONE, ONE, ONE, -ONE, -ONE, -ONE};
        set_box(bx);
        send_ray(mk(-4*ONE, 0, 0, ONE, 0, 0), -1);
        send_ray(mk(-4*ONE, -4*ONE, -4*ONE, ONE, ONE, ONE), 1);
        bx = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        set_box(bx);
        send_ray(mk(0, 0, 0, ONE, ONE, ONE), 0);
        send_ray(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0), -1);

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3) begin
                foreach (bx[k]) bx[k] = $urandom();
            end else begin
                for (int a = 0; a < 3; a++) begin
                    bx[a]     = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
                    bx[a + 3] = bx[a] + $urandom_range(0, 20 << 16);
                end
            end
            set_box(bx);
            if (phase == 1) long_hold = 1;
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                if ($urandom_range(0, 3) != 0) r = aimed_ray();
                else for (int a = 0; a < 3; a++) begin
                    r.org[a] = rand_q(16 << 16);
                    r.dir[a] = rand_q(4 << 16);
                end
                send_ray(r, -1);
                if (phase != 1 || n > 80) in_gap(40);
                if (phase == 2 && n == 100) wait_idle();   // sender drains out
            end
        end
        wait_idle();
        stim_done = 1;
    end

    // receiver
    initial begin
        int n;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                long_hold = 0;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            n = ($urandom_range(0, 3) == 0) ? gap_len(40) : 0;
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        logic e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (hit_queue.size() == 0) begin
                $display("%0t: output beat with nothing expected, actual hit %0b",
                         $time, o_hit);
                errors++;
            end else begin
                e = hit_queue.pop_front();
                if (o_hit !== e) begin
                    $display("%0t: hit mismatch: expected %0b, actual %0b",
                             $time, e, o_hit);
                    errors++;
                end
            end
        end
    end

    // watchdog and end of run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end else if (stim_done) begin
            if (errors == 0 && hit_queue.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule
